>>> hdl/psc_pkg.sv
// Shared types, constants and character-class functions for the printf specifier scanner.
`timescale 1ns / 1ps
`default_nettype none

package psc_pkg;

  // Default sizes of the scanner.
  localparam int OFFSET_BITS_DEF = 12;
  localparam int TYPE_CHARS_DEF  = 7;

  // Fixed widths of the result fields.
  localparam int OUT_OFF_W   = 12;
  localparam int TYPE_OUT_W  = 56;
  localparam int TYPE_LEN_W  = 3;
  localparam int COUNT_W     = 6;
  localparam int CH_W        = 8;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 96;

  localparam logic [COUNT_W-1:0] MAX_SPECS_RST = 6'd32;

  // Characters that steer the scan.
  localparam logic [CH_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CH_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [CH_W-1:0] CH_DOLLAR  = 8'h24;
  localparam logic [CH_W-1:0] CH_DOT     = 8'h2E;
  localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE    = 8'h39;

  // Result kinds carried on tuser.
  localparam logic KIND_SPEC = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [3:0] {
    M_PLAIN  = 4'd0,
    M_PCT    = 4'd1,
    M_HALT   = 4'd2,
    M_POSDIG = 4'd3,
    M_FLAGS  = 4'd4,
    M_WIDTH  = 4'd5,
    M_DOT    = 4'd6,
    M_PREC   = 4'd7,
    M_MOD    = 4'd8
  } mode_t;

  typedef struct packed {
    logic                  kind;
    logic [OUT_OFF_W-1:0]  spec_start;
    logic [OUT_OFF_W-1:0]  spec_length;
    logic                  pos_given;
    logic                  is_numeric;
    logic [TYPE_OUT_W-1:0] type_chars;
    logic [TYPE_LEN_W-1:0] type_length;
    logic [COUNT_W-1:0]    spec_count;
  } res_t;

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Flag characters: - + space # 0 '
  function automatic logic is_flag(input logic [CH_W-1:0] c);
    return c inside {8'h2D, 8'h2B, 8'h20, 8'h23, 8'h30, 8'h27};
  endfunction

  // Length modifiers: h l L q j z t
  function automatic logic is_modifier(input logic [CH_W-1:0] c);
    return c inside {8'h68, 8'h6C, 8'h4C, 8'h71, 8'h6A, 8'h7A, 8'h74};
  endfunction

  // Numeric conversions: d i u f F e E g G a A
  function automatic logic numeric_conv(input logic [CH_W-1:0] c);
    return c inside {8'h64, 8'h69, 8'h75, 8'h66, 8'h46, 8'h65, 8'h45,
                     8'h67, 8'h47, 8'h61, 8'h41};
  endfunction

endpackage

`default_nettype wire

>>> hdl/printf_spec_scanner.sv
// Top level of the printf specifier scanner: stream ports, input and result registers.
//
//   Channel  Direction  Handshake            Payload
//   in_      slave      in_tvalid/in_tready  in_tdata = ch, in_tlast = end_of_string
//   out_     master     out_tvalid/out_tready out_tdata = result fields, out_tuser = kind
//   cfg_     write only cfg_we               cfg_wdata = max_specs
//
// Each character is accepted into an input register and scanned from there; a
// result, if any, is loaded into the output register as the character is scanned,
// and out_tvalid is driven by that register. One character per cycle is sustained
// while results are taken; the combinational scan step sets the rate.
// Reset (synchronous, active low) returns the scan to plain text at offset zero
// and sets max_specs to 32. When the output register holds a result that is not
// taken, characters that would make a result wait in the input register, and
// in_tready drops once that register is occupied by such a character.
`timescale 1ns / 1ps
`default_nettype none

module printf_spec_scanner #(
  parameter int OFFSET_BITS = psc_pkg::OFFSET_BITS_DEF,
  parameter int TYPE_CHARS  = psc_pkg::TYPE_CHARS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input stream.
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [psc_pkg::IN_TDATA_W-1:0]    in_tdata,  // [7:0] ch
  input  wire logic                              in_tlast,  // end_of_string
  // Result stream.
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [11:0] spec_start, [23:12] spec_length, [24] pos_given, [25] is_numeric,
  // [81:26] type_chars, [84:82] type_length, [90:85] spec_count, [95:91] zero
  output logic [psc_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic                                   out_tuser, // [0] kind
  // Configuration.
  input  wire logic                              cfg_we,
  input  wire logic [psc_pkg::COUNT_W-1:0]       cfg_wdata  // max_specs
);
  import psc_pkg::*;

  // Configuration register.
  logic [COUNT_W-1:0] max_specs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_specs_r <= MAX_SPECS_RST;
    end else if (cfg_we) begin
      max_specs_r <= cfg_wdata;
    end
  end

  // Input register stage.
  logic            s1_valid_r, s1_valid_nxt;
  logic [CH_W-1:0] s1_ch_r;
  logic            s1_eos_r;
  logic            s1_fire;
  logic            in_fire;

  // Result register stage.
  logic            out_valid_r, out_valid_nxt;
  res_t            out_res_r;
  logic            out_free;

  logic            core_res_valid;
  res_t            core_res;

  assign out_free = !out_valid_r || out_tready;
  // A character that makes no result can always advance; one that does needs room.
  assign s1_fire  = s1_valid_r && (out_free || !core_res_valid);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire  = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !s1_fire);
  assign out_valid_nxt = (out_valid_r && !out_tready) || (s1_fire && core_res_valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ch_r  <= in_tdata[CH_W-1:0];
      s1_eos_r <= in_tlast;
    end
    if (s1_fire && core_res_valid) begin
      out_res_r <= core_res;
    end
  end

  psc_core #(
    .OFFSET_BITS (OFFSET_BITS),
    .TYPE_CHARS  (TYPE_CHARS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (s1_fire),
    .ch        (s1_ch_r),
    .eos       (s1_eos_r),
    .max_specs (max_specs_r),
    .res_valid (core_res_valid),
    .res       (core_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {5'b0,
                       out_res_r.spec_count,
                       out_res_r.type_length,
                       out_res_r.type_chars,
                       out_res_r.is_numeric,
                       out_res_r.pos_given,
                       out_res_r.spec_length,
                       out_res_r.spec_start};

endmodule

`default_nettype wire

>>> hdl/psc_core.sv
// Scan state registers and the one-character step logic of the specifier scanner.
`timescale 1ns / 1ps
`default_nettype none

module psc_core #(
  parameter int OFFSET_BITS = psc_pkg::OFFSET_BITS_DEF,
  parameter int TYPE_CHARS  = psc_pkg::TYPE_CHARS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step_en,
  input  wire logic [psc_pkg::CH_W-1:0]     ch,
  input  wire logic                         eos,
  input  wire logic [psc_pkg::COUNT_W-1:0]  max_specs,
  output logic                              res_valid,
  output psc_pkg::res_t                     res
);
  import psc_pkg::*;

  localparam int FILL_W = $clog2(TYPE_CHARS + 1);
  localparam int BUF_W  = 8 * TYPE_CHARS;

  mode_t               mode_r,   mode_nxt;
  logic [OFFSET_BITS-1:0] offset_r, offset_nxt;
  logic [OFFSET_BITS-1:0] start_r,  start_nxt;
  logic [COUNT_W-1:0]  found_r,  found_nxt;
  logic                pos_r,    pos_nxt;
  logic                daz_r,    daz_nxt;
  logic [BUF_W-1:0]    buf_r,    buf_nxt;
  logic [FILL_W-1:0]   fill_r,   fill_nxt;

  // Values the specifier body starts from; a fresh specifier begins cleared.
  logic                body_go;
  mode_t               body_m;
  mode_t               m_eff;
  logic                done;
  logic                pos_b;
  logic [BUF_W-1:0]    buf_b;
  logic [FILL_W-1:0]   fill_b;
  logic [BUF_W-1:0]    buf_kept;
  logic [FILL_W-1:0]   fill_kept;
  logic                is_end;

  logic [OFFSET_BITS:0]           len_wide;
  logic [OFFSET_BITS-1:0]         len_sat;
  logic [OFFSET_BITS+OUT_OFF_W-1:0] start_ext;
  logic [OFFSET_BITS+OUT_OFF_W-1:0] len_ext;
  logic [BUF_W+TYPE_OUT_W-1:0]    buf_ext;
  logic [FILL_W+TYPE_LEN_W-1:0]   fill_ext;

  // Length from the percent sign through the current character, saturated.
  assign len_wide = {1'b0, offset_r} - {1'b0, start_r} + (OFFSET_BITS+1)'(1);
  assign len_sat  = ((offset_r < start_r) || len_wide[OFFSET_BITS]) ?
                    '1 : len_wide[OFFSET_BITS-1:0];

  assign start_ext = {{OUT_OFF_W{1'b0}}, start_r};
  assign len_ext   = {{OUT_OFF_W{1'b0}}, len_sat};
  assign buf_ext   = {{TYPE_OUT_W{1'b0}}, buf_kept};
  assign fill_ext  = {{TYPE_LEN_W{1'b0}}, fill_kept};

  // Append the character to the type buffer while room is left.
  always_comb begin
    buf_kept  = buf_b;
    fill_kept = fill_b;
    if (fill_b < FILL_W'(TYPE_CHARS)) begin
      for (int i = 0; i < TYPE_CHARS; i++) begin
        if (fill_b == FILL_W'(i)) begin
          buf_kept[8*i +: 8] = ch;
        end
      end
      fill_kept = fill_b + FILL_W'(1);
    end
  end

  assign is_end = eos || (ch == CH_NUL);

  always_comb begin
    mode_nxt   = mode_r;
    offset_nxt = offset_r;
    start_nxt  = start_r;
    found_nxt  = found_r;
    pos_nxt    = pos_r;
    daz_nxt    = daz_r;
    buf_nxt    = buf_r;
    fill_nxt   = fill_r;
    res_valid  = 1'b0;
    res        = '0;
    body_go    = 1'b0;
    body_m     = mode_r;
    pos_b      = pos_r;
    buf_b      = buf_r;
    fill_b     = fill_r;
    m_eff      = mode_r;
    done       = 1'b0;

    if (is_end) begin
      res_valid       = 1'b1;
      res.kind        = KIND_END;
      res.spec_count  = found_r;
      mode_nxt        = M_PLAIN;
      offset_nxt      = '0;
      start_nxt       = '0;
      found_nxt       = '0;
      pos_nxt         = 1'b0;
      daz_nxt         = 1'b0;
      buf_nxt         = '0;
      fill_nxt        = '0;
    end else begin
      case (mode_r)
        M_PLAIN: begin
          if (ch == CH_PERCENT) begin
            start_nxt = offset_r;
            mode_nxt  = M_PCT;
          end
        end
        M_PCT: begin
          if (ch == CH_PERCENT) begin
            mode_nxt = M_PLAIN;
          end else if (found_r >= max_specs) begin
            mode_nxt = M_HALT;
          end else begin
            pos_nxt  = 1'b0;
            buf_nxt  = '0;
            fill_nxt = '0;
            if (is_digit(ch)) begin
              daz_nxt  = (ch == CH_ZERO);
              mode_nxt = M_POSDIG;
            end else begin
              daz_nxt = 1'b0;
              body_go = 1'b1;
              body_m  = M_FLAGS;
              pos_b   = 1'b0;
              buf_b   = '0;
              fill_b  = '0;
            end
          end
        end
        M_POSDIG, M_FLAGS, M_WIDTH, M_PREC, M_MOD: begin
          body_go = 1'b1;
        end
        M_HALT: begin
          mode_nxt = M_HALT;
        end
        default: begin
          mode_nxt = M_PLAIN;
        end
      endcase

      // Specifier body: each part either takes the character or hands it on.
      if (body_go) begin
        m_eff = body_m;
        if (m_eff == M_POSDIG) begin
          if (is_digit(ch)) begin
            if (ch != CH_ZERO) begin
              daz_nxt = 1'b0;
            end
            done = 1'b1;
          end else if (ch == CH_DOLLAR) begin
            pos_nxt  = 1'b1;
            mode_nxt = M_FLAGS;
            done     = 1'b1;
          end else begin
            m_eff = daz_r ? M_FLAGS : M_DOT;
          end
        end
        if (!done && m_eff == M_FLAGS) begin
          if (is_flag(ch)) begin
            mode_nxt = M_FLAGS;
            done     = 1'b1;
          end else if (is_digit(ch)) begin
            mode_nxt = M_WIDTH;
            done     = 1'b1;
          end else begin
            m_eff = M_DOT;
          end
        end
        if (!done && m_eff == M_WIDTH) begin
          if (is_digit(ch)) begin
            mode_nxt = M_WIDTH;
            done     = 1'b1;
          end else begin
            m_eff = M_DOT;
          end
        end
        if (!done && m_eff == M_DOT) begin
          if (ch == CH_DOT) begin
            mode_nxt = M_PREC;
            done     = 1'b1;
          end else begin
            m_eff = M_MOD;
          end
        end
        if (!done && m_eff == M_PREC) begin
          if (is_digit(ch)) begin
            mode_nxt = M_PREC;
            done     = 1'b1;
          end else begin
            m_eff = M_MOD;
          end
        end
        if (!done) begin
          buf_nxt  = buf_kept;
          fill_nxt = fill_kept;
          if (is_modifier(ch)) begin
            mode_nxt = M_MOD;
          end else begin
            res_valid        = 1'b1;
            res.kind         = KIND_SPEC;
            res.spec_start   = start_ext[OUT_OFF_W-1:0];
            res.spec_length  = len_ext[OUT_OFF_W-1:0];
            res.pos_given    = pos_b;
            res.is_numeric   = numeric_conv(ch);
            res.type_chars   = buf_ext[TYPE_OUT_W-1:0];
            res.type_length  = fill_ext[TYPE_LEN_W-1:0];
            found_nxt        = found_r + COUNT_W'(1);
            mode_nxt         = M_PLAIN;
          end
        end
      end

      if (offset_r != '1) begin
        offset_nxt = offset_r + OFFSET_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_PLAIN;
      offset_r <= '0;
      start_r  <= '0;
      found_r  <= '0;
      pos_r    <= 1'b0;
      daz_r    <= 1'b0;
      buf_r    <= '0;
      fill_r   <= '0;
    end else if (step_en) begin
      mode_r   <= mode_nxt;
      offset_r <= offset_nxt;
      start_r  <= start_nxt;
      found_r  <= found_nxt;
      pos_r    <= pos_nxt;
      daz_r    <= daz_nxt;
      buf_r    <= buf_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/psc_checker.sv
// Port-level checker for the printf specifier scanner and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module psc_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [psc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input wire logic                              out_tuser
);
  import psc_pkg::*;

  // A result that is not taken stays on the bus unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // End-of-string transactions carry only the count.
  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_END) |-> out_tdata[84:0] == '0)
    else $error("end transaction has nonzero specifier fields");

  // Specifier transactions carry no count and at least one type byte.
  a_spec_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_SPEC) |->
      (out_tdata[90:85] == '0) && (out_tdata[84:82] != '0) && (out_tdata[95:91] == '0))
    else $error("specifier transaction has malformed fields");

  // The input side only stalls behind a result that is waiting on the output.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a waiting result");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind printf_spec_scanner psc_checker u_psc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
